### src/amgs_pkg.sv
// Shared types and constants for the adjacency matrix graph store.
// Used by the front end, the command queue, the back end and the top level.
package amgs_pkg;

   localparam int VERTEX_WIDTH = 4;
   localparam int MAX_ROWS     = 2 ** VERTEX_WIDTH;
   localparam int EXT_WIDTH    = 7;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QCOUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_QUERY = 2'd1;
   localparam logic [1:0] OP_LIST  = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      logic [VERTEX_WIDTH-1:0] a;
      logic [VERTEX_WIDTH-1:0] b;
      logic                    a_ok;
      logic                    b_ok;
   } cmd_type;

endpackage

### src/adjacency_matrix_graph_store.sv
// Top level of the adjacency matrix graph store: front end, queue, back end.
// Depends on amgs_pkg, amgs_front, amgs_queue and amgs_back.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    op, vertex_a, vertex_b
//   rsp      out        rsp_valid/stall    is_adjacent, neighbor, found, last
//
// Add edge gives no result word; query gives one result word.
// Listing loads the row, then gives one result word per set bit (at least
// one word, for an empty row), set by the back-end row scan.
// Reset clears the matrix in the same cycle; no clearing pass.
// The two-entry queue keeps intake open while the back end scans or rsp stalls.
module adjacency_matrix_graph_store #(
   parameter int VERTICES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_a,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_b,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_adjacent,
   output logic [amgs_pkg::VERTEX_WIDTH-1:0] rsp_neighbor,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   amgs_pkg::cmd_type push_cmd, head_cmd;
   logic push, full, pop, not_empty;

   amgs_front #(.VERTICES(VERTICES)) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_vertex_a (req_vertex_a),
      .req_vertex_b (req_vertex_b),
      .queue_full   (full),
      .push         (push),
      .cmd          (push_cmd)
   );

   amgs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (full),
      .pop       (pop),
      .not_empty (not_empty),
      .head_cmd  (head_cmd)
   );

   amgs_back #(.VERTICES(VERTICES)) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (not_empty),
      .cmd             (head_cmd),
      .cmd_pop         (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_adjacent (rsp_is_adjacent),
      .rsp_neighbor    (rsp_neighbor),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

endmodule

### src/amgs_front.sv
// Front end: takes request words, checks vertex range and drops unused ops.
// Depends on amgs_pkg.
module amgs_front #(
   parameter int VERTICES = 16
) (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_a,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_b,
   input  logic                              queue_full,
   output logic                              push,
   output amgs_pkg::cmd_type                 cmd
);

   localparam logic [amgs_pkg::EXT_WIDTH-1:0] VCOUNT = amgs_pkg::EXT_WIDTH'(VERTICES);

   logic known_op;
   logic [amgs_pkg::EXT_WIDTH-1:0] a_ext;
   logic [amgs_pkg::EXT_WIDTH-1:0] b_ext;

   always_comb begin
      a_ext = amgs_pkg::EXT_WIDTH'(req_vertex_a);
      b_ext = amgs_pkg::EXT_WIDTH'(req_vertex_b);
      known_op = (req_op == amgs_pkg::OP_ADD) || (req_op == amgs_pkg::OP_QUERY) ||
                 (req_op == amgs_pkg::OP_LIST);
      cmd.kind = req_op;
      cmd.a    = req_vertex_a;
      cmd.b    = req_vertex_b;
      cmd.a_ok = a_ext < VCOUNT;
      cmd.b_ok = b_ext < VCOUNT;
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && known_op;

endmodule

### src/amgs_queue.sv
// Short command queue between the front end and the back end.
// Depends on amgs_pkg for the command type and depth.
module amgs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  amgs_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output amgs_pkg::cmd_type head_cmd
);

   amgs_pkg::cmd_type slots_ff [amgs_pkg::QUEUE_DEPTH];
   logic [amgs_pkg::QCOUNT_WIDTH-1:0] count_ff, count_in;
   logic [$clog2(amgs_pkg::QUEUE_DEPTH)-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;

   logic do_push, do_pop;

   always_comb begin
      full      = count_ff == amgs_pkg::QCOUNT_WIDTH'(amgs_pkg::QUEUE_DEPTH);
      not_empty = count_ff != '0;
      head_cmd  = slots_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      count_in  = count_ff + amgs_pkg::QCOUNT_WIDTH'(do_push)
                  - amgs_pkg::QCOUNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
      end else begin
         count_ff  <= count_in;
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### src/amgs_back.sv
// Back end: holds the adjacency bit matrix, executes commands, scans rows.
// Depends on amgs_pkg; fed by amgs_queue.
module amgs_back #(
   parameter int VERTICES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  amgs_pkg::cmd_type                 cmd,
   output logic                              cmd_pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_is_adjacent,
   output logic [amgs_pkg::VERTEX_WIDTH-1:0] rsp_neighbor,
   output logic                              rsp_found,
   output logic                              rsp_last
);

   localparam int ROWS = (VERTICES < amgs_pkg::MAX_ROWS) ? VERTICES : amgs_pkg::MAX_ROWS;
   localparam int RIDX = $clog2(ROWS);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic [ROWS-1:0] rows_ff [ROWS];
   logic [ROWS-1:0] rows_in [ROWS];
   logic [ROWS-1:0] rem_ff, rem_in;
   logic state_ff, state_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic adj_ff, adj_in;
   logic [amgs_pkg::VERTEX_WIDTH-1:0] nb_ff, nb_in;
   logic found_ff, found_in;
   logic last_ff, last_in;

   logic [RIDX-1:0] a_idx, b_idx;
   logic [ROWS-1:0] row_a, low_bit, rest;
   logic [amgs_pkg::VERTEX_WIDTH-1:0] low_index;
   logic out_free, add_en;

   always_comb begin
      a_idx   = cmd.a[RIDX-1:0];
      b_idx   = cmd.b[RIDX-1:0];
      row_a   = rows_ff[a_idx];
      low_bit = rem_ff & (~rem_ff + 1'b1);
      rest    = rem_ff & ~low_bit;
      low_index = '0;
      for (int j = 0; j < ROWS; j++) begin
         if (low_bit[j]) begin
            low_index = low_index | amgs_pkg::VERTEX_WIDTH'(j);
         end
      end
   end

   always_comb begin
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      adj_in       = adj_ff;
      nb_in        = nb_ff;
      found_in     = found_ff;
      last_in      = last_ff;
      rem_in       = rem_ff;
      state_in     = state_ff;
      cmd_pop      = 1'b0;
      add_en       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  amgs_pkg::OP_ADD: begin
                     cmd_pop = 1'b1;
                     add_en  = cmd.a_ok && cmd.b_ok;
                  end
                  amgs_pkg::OP_QUERY: begin
                     if (out_free) begin
                        cmd_pop      = 1'b1;
                        rsp_valid_in = 1'b1;
                        adj_in       = cmd.a_ok && cmd.b_ok && row_a[b_idx];
                        nb_in        = '0;
                        found_in     = 1'b0;
                        last_in      = 1'b1;
                     end
                  end
                  amgs_pkg::OP_LIST: begin
                     cmd_pop  = 1'b1;
                     rem_in   = cmd.a_ok ? row_a : '0;
                     state_in = ST_LIST;
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               adj_in       = 1'b0;
               if (rem_ff == '0) begin
                  nb_in    = '0;
                  found_in = 1'b0;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  nb_in    = low_index;
                  found_in = 1'b1;
                  last_in  = rest == '0;
                  rem_in   = rest;
                  if (rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
      endcase
   end

   always_comb begin
      for (int r = 0; r < ROWS; r++) begin
         rows_in[r] = rows_ff[r];
      end
      if (add_en) begin
         rows_in[a_idx][b_idx] = 1'b1;
         rows_in[b_idx][a_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            rows_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int r = 0; r < ROWS; r++) begin
            rows_ff[r] <= rows_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      adj_ff   <= adj_in;
      nb_ff    <= nb_in;
      found_ff <= found_in;
      last_ff  <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_adjacent = adj_ff;
   assign rsp_neighbor    = nb_ff;
   assign rsp_found       = found_ff;
   assign rsp_last        = last_ff;

endmodule

### verif/graph_store_checker.sv
`timescale 1ns / 1ps
// Checker for the adjacency matrix graph store: keeps its own edge matrix,
// predicts every rsp word from the accepted req words and compares them.
// Depends on amgs_pkg for the op codes and the vertex width.
module graph_store_checker #(
   parameter int VERTICES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_a,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_b,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_is_adjacent,
   input  logic [amgs_pkg::VERTEX_WIDTH-1:0] rsp_neighbor,
   input  logic                              rsp_found,
   input  logic                              rsp_last,
   output int                                mismatches,
   output int                                answers_pending
);

   typedef struct packed {
      logic                              is_adjacent;
      logic [amgs_pkg::VERTEX_WIDTH-1:0] neighbor;
      logic                              found;
      logic                              last;
   } answer_type;

   logic [VERTICES-1:0] edge_rows [VERTICES];
   answer_type          answers_due [$];
   answer_type          got;
   answer_type          want;
   int                  fail_count = 0;

   function automatic string show(input answer_type w);
      return $sformatf("adj=%0d neighbor=%0d found=%0d last=%0d",
                       w.is_adjacent, w.neighbor, w.found, w.last);
   endfunction

   task automatic predict_answers(input logic [1:0] op,
                                  input logic [amgs_pkg::VERTEX_WIDTH-1:0] a,
                                  input logic [amgs_pkg::VERTEX_WIDTH-1:0] b);
      logic [VERTICES-1:0] row;
      bit                  a_in;
      bit                  b_in;
      int                  last_hit;
      answer_type          ans;
      a_in     = a < VERTICES;
      b_in     = b < VERTICES;
      row      = '0;
      last_hit = -1;
      case (op)
         amgs_pkg::OP_ADD: begin
            if (a_in && b_in) begin
               edge_rows[a][b] = 1'b1;
               edge_rows[b][a] = 1'b1;
            end
         end
         amgs_pkg::OP_QUERY: begin
            ans      = '0;
            ans.last = 1'b1;
            if (a_in && b_in)
               ans.is_adjacent = edge_rows[a][b];
            answers_due.push_back(ans);
         end
         amgs_pkg::OP_LIST: begin
            if (a_in)
               row = edge_rows[a];
            for (int v = 0; v < VERTICES; v++)
               if (row[v])
                  last_hit = v;
            if (last_hit < 0) begin
               ans      = '0;
               ans.last = 1'b1;
               answers_due.push_back(ans);
            end else begin
               for (int v = 0; v < VERTICES; v++) begin
                  if (row[v]) begin
                     ans          = '0;
                     ans.neighbor = v[amgs_pkg::VERTEX_WIDTH-1:0];
                     ans.found    = 1'b1;
                     ans.last     = (v == last_hit);
                     answers_due.push_back(ans);
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VERTICES; v++)
            edge_rows[v] = '0;
         answers_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.is_adjacent = rsp_is_adjacent;
            got.neighbor    = rsp_neighbor;
            got.found       = rsp_found;
            got.last        = rsp_last;
            if (answers_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: rsp word with nothing due: %s", $time, show(got));
            end else begin
               want = answers_due.pop_front();
               if (got.is_adjacent !== want.is_adjacent || got.neighbor !== want.neighbor ||
                   got.found !== want.found || got.last !== want.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: rsp mismatch, expected %s, actual %s",
                              $time, show(want), show(got));
               end
            end
         end
         if (req_valid && !req_stall)
            predict_answers(req_op, req_vertex_a, req_vertex_b);
      end
      mismatches      <= fail_count;
      answers_pending <= answers_due.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Testbench top for the adjacency matrix graph store: clock, reset, req and rsp
// stimulus over several idle and stall phases, and the verdict.
// Depends on amgs_pkg, adjacency_matrix_graph_store and graph_store_checker.
module tb;

   localparam int         VERTICES  = 16;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic                              clock           = 1'b0;
   logic                              reset           = 1'b1;
   logic                              req_valid       = 1'b0;
   logic                              req_stall;
   logic [1:0]                        req_op          = amgs_pkg::OP_ADD;
   logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_a    = '0;
   logic [amgs_pkg::VERTEX_WIDTH-1:0] req_vertex_b    = '0;
   logic                              rsp_valid;
   logic                              rsp_stall       = 1'b0;
   logic                              rsp_is_adjacent;
   logic [amgs_pkg::VERTEX_WIDTH-1:0] rsp_neighbor;
   logic                              rsp_found;
   logic                              rsp_last;
   int                                mismatches;
   int                                answers_pending;
   int                                idle_pct        = 0;
   int                                stall_pct       = 0;

   adjacency_matrix_graph_store #(.VERTICES(VERTICES)) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_adjacent (rsp_is_adjacent),
      .rsp_neighbor    (rsp_neighbor),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

   graph_store_checker #(.VERTICES(VERTICES)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_adjacent (rsp_is_adjacent),
      .rsp_neighbor    (rsp_neighbor),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .answers_pending (answers_pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   task automatic send_word(input logic [1:0] op,
                            input logic [amgs_pkg::VERTEX_WIDTH-1:0] a,
                            input logic [amgs_pkg::VERTEX_WIDTH-1:0] b);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= op;
      req_vertex_a <= a;
      req_vertex_b <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic send_random();
      int                                pick;
      logic [amgs_pkg::VERTEX_WIDTH-1:0] a;
      logic [amgs_pkg::VERTEX_WIDTH-1:0] b;
      pick = $urandom_range(0, 99);
      a    = amgs_pkg::VERTEX_WIDTH'($urandom_range(0, VERTICES - 1));
      b    = amgs_pkg::VERTEX_WIDTH'($urandom_range(0, VERTICES - 1));
      if ($urandom_range(0, 99) < 8)
         send_word(OP_UNUSED, b, a);
      if (pick < 40)
         send_word(amgs_pkg::OP_ADD, a, b);
      else if (pick < 70)
         send_word(amgs_pkg::OP_QUERY, a, b);
      else
         send_word(amgs_pkg::OP_LIST, a, b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_pending != 0)
         @(posedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_word(amgs_pkg::OP_QUERY, 4'd0, 4'd0);
      send_word(amgs_pkg::OP_LIST, 4'd0, 4'd15);
      send_word(amgs_pkg::OP_LIST, 4'd15, 4'd0);
      send_word(amgs_pkg::OP_ADD, 4'd0, 4'd15);
      send_word(amgs_pkg::OP_ADD, 4'd15, 4'd15);
      send_word(amgs_pkg::OP_QUERY, 4'd0, 4'd15);
      send_word(amgs_pkg::OP_QUERY, 4'd15, 4'd0);
      send_word(amgs_pkg::OP_QUERY, 4'd15, 4'd15);
      send_word(amgs_pkg::OP_QUERY, 4'd15, 4'd14);
      send_word(amgs_pkg::OP_LIST, 4'd15, 4'd0);
      send_word(amgs_pkg::OP_LIST, 4'd0, 4'd0);
      send_word(amgs_pkg::OP_ADD, 4'd7, 4'd7);
      send_word(amgs_pkg::OP_LIST, 4'd7, 4'd0);
      send_word(OP_UNUSED, 4'd15, 4'd15);
      send_word(OP_UNUSED, 4'd0, 4'd0);
      send_word(amgs_pkg::OP_QUERY, 4'd15, 4'd15);
      send_word(amgs_pkg::OP_ADD, 4'd1, 4'd2);
      send_word(amgs_pkg::OP_ADD, 4'd3, 4'd2);
      send_word(amgs_pkg::OP_LIST, 4'd2, 4'd0);
      send_word(amgs_pkg::OP_QUERY, 4'd3, 4'd1);
      send_word(amgs_pkg::OP_ADD, 4'd14, 4'd0);
      send_word(amgs_pkg::OP_LIST, 4'd0, 4'd0);
      drain();

      repeat (57) send_random();
      drain();

      idle_pct = 49;
      repeat (57) send_random();
      drain();

      idle_pct  = 0;
      stall_pct = 49;
      repeat (57) send_random();
      drain();

      idle_pct  = 17;
      stall_pct = 17;
      repeat (57) send_random();
      drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && answers_pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### adjacency_matrix_graph_store.f
src/amgs_pkg.sv
src/amgs_front.sv
src/amgs_queue.sv
src/amgs_back.sv
src/adjacency_matrix_graph_store.sv
verif/graph_store_checker.sv
verif/tb.sv
